/* src/mb2b_pkg.sv */
// ----------------------------------------------------------------------------
// mb2b_pkg: shared types and constants for the multibyte to two-byte code core.
// Holds the mode codes, the item layout between the input stage and the
// converter, and the byte range limits used by the lead byte checks.
// ----------------------------------------------------------------------------
package mb2b_pkg;

    // Conversion modes as written through the configuration port.
    typedef enum logic [1:0] {
        MODE_SINGLE = 2'd0,
        MODE_WIDE   = 2'd1,
        MODE_SJIS   = 2'd2,
        MODE_EUC    = 2'd3
    } code_mode_t;

    // One input code unit with its end-of-string flag.
    typedef struct packed {
        logic [15:0] code_in;
        logic        end_mark;
    } unit_item_t;

    // Shift-JIS lead byte ranges and row/cell offsets.
    localparam logic [7:0] SJIS_LEAD1_LO = 8'h80;
    localparam logic [7:0] SJIS_LEAD1_HI = 8'h9f;
    localparam logic [7:0] SJIS_LEAD2_LO = 8'he0;
    localparam logic [7:0] SJIS_LEAD2_HI = 8'hfc;
    localparam logic [8:0] SJIS_ROW_OFS1 = 9'h0e0;
    localparam logic [8:0] SJIS_ROW_OFS2 = 9'h160;
    localparam logic [7:0] SJIS_TRAIL_MID = 8'h7f;
    localparam logic [7:0] SJIS_CELL_OFS1 = 8'h1f;
    localparam logic [7:0] SJIS_CELL_OFS2 = 8'h20;
    localparam logic [7:0] SJIS_CELL_OFS3 = 8'h7e;
    localparam logic [7:0] LOW7_MASK      = 8'h7f;

endpackage

/* src/mb2b_in_skid.sv */
// ----------------------------------------------------------------------------
// mb2b_in_skid: input register with a skid entry.
// Registers each accepted code unit and keeps the ready toward the source
// driven from a flip-flop, so backpressure never reaches it combinationally.
// ----------------------------------------------------------------------------
module mb2b_in_skid
    import mb2b_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  unit_item_t in_item,
    output logic       out_valid,
    output unit_item_t out_item,
    input  logic       out_pop
);

    logic       main_valid_reg;
    logic       main_valid_next;
    unit_item_t main_reg;
    logic       skid_valid_reg;
    logic       skid_valid_next;
    unit_item_t skid_reg;
    logic       push;

    assign in_ready  = ~skid_valid_reg;
    assign push      = in_valid & in_ready;
    assign out_valid = main_valid_reg;
    assign out_item  = main_reg;

    // Occupancy of the main and skid entries.
    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_pop) begin
            if (skid_valid_reg) begin
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                main_valid_next = push;
            end
        end else if (push) begin
            if (main_valid_reg) begin
                skid_valid_next = 1'b1;
            end else begin
                main_valid_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload entries.
    always_ff @(posedge aclk) begin
        if (out_pop) begin
            if (skid_valid_reg) begin
                main_reg <= skid_reg;
            end else if (push) begin
                main_reg <= in_item;
            end
        end else if (push) begin
            if (main_valid_reg) begin
                skid_reg <= in_item;
            end else begin
                main_reg <= in_item;
            end
        end
    end

endmodule

/* src/mb2b_convert.sv */
// ----------------------------------------------------------------------------
// mb2b_convert: code conversion and result register.
// Holds the mode register and the pending lead byte, maps each registered
// code unit to a two-byte font code and loads it into the result register.
// ----------------------------------------------------------------------------
module mb2b_convert
    import mb2b_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [1:0] cfg_wdata,
    input  logic       unit_valid,
    input  unit_item_t unit_item,
    output logic       unit_pop,
    output logic       res_valid,
    input  logic       res_ready,
    output logic [7:0] res_high_byte,
    output logic [7:0] res_low_byte,
    output logic       res_last_char
);

    code_mode_t  mode_reg;
    logic        lead_pending_reg;
    logic        lead_pending_next;
    logic [7:0]  lead_byte_reg;
    logic [7:0]  lead_byte_next;
    logic        res_valid_reg;
    logic        res_valid_next;
    logic [7:0]  high_reg;
    logic [7:0]  low_reg;
    logic        last_reg;

    logic [7:0]  cur_byte;
    logic        is_lead;
    logic        emit;
    logic [7:0]  high_val;
    logic [7:0]  low_val;
    logic [8:0]  lead_x2;
    logic [8:0]  sjis_row_base;
    logic [7:0]  sjis_row;
    logic [7:0]  sjis_cell;

    assign cur_byte = unit_item.code_in[7:0];
    assign unit_pop = unit_valid & (~res_valid_reg | res_ready);

    // Shift-JIS row and cell from the held lead and the current trail.
    always_comb begin
        lead_x2 = {lead_byte_reg, 1'b0};
        if (lead_byte_reg <= SJIS_LEAD1_HI) begin
            sjis_row_base = lead_x2 - SJIS_ROW_OFS1;
        end else begin
            sjis_row_base = lead_x2 - SJIS_ROW_OFS2;
        end
        if (cur_byte < SJIS_LEAD1_HI) begin
            sjis_row = sjis_row_base[7:0] - 8'd1;
            if (cur_byte < SJIS_TRAIL_MID) begin
                sjis_cell = cur_byte - SJIS_CELL_OFS1;
            end else begin
                sjis_cell = cur_byte - SJIS_CELL_OFS2;
            end
        end else begin
            sjis_row  = sjis_row_base[7:0];
            sjis_cell = cur_byte - SJIS_CELL_OFS3;
        end
    end

    // Lead byte detection depends on the mode.
    always_comb begin
        if (mode_reg == MODE_SJIS) begin
            is_lead = ((cur_byte >= SJIS_LEAD1_LO) && (cur_byte <= SJIS_LEAD1_HI)) ||
                      ((cur_byte >= SJIS_LEAD2_LO) && (cur_byte <= SJIS_LEAD2_HI));
        end else begin
            is_lead = cur_byte[7];
        end
    end

    // Result selection and lead byte bookkeeping.
    always_comb begin
        emit              = 1'b1;
        high_val          = 8'd0;
        low_val           = cur_byte;
        lead_pending_next = lead_pending_reg;
        lead_byte_next    = lead_byte_reg;
        case (mode_reg)
            MODE_SINGLE: begin
                high_val = 8'd0;
            end
            MODE_WIDE: begin
                high_val = unit_item.code_in[15:8];
            end
            MODE_SJIS, MODE_EUC: begin
                if (lead_pending_reg) begin
                    lead_pending_next = 1'b0;
                    lead_byte_next    = 8'd0;
                    if (mode_reg == MODE_SJIS) begin
                        high_val = sjis_row;
                        low_val  = sjis_cell;
                    end else begin
                        high_val = lead_byte_reg & LOW7_MASK;
                        low_val  = cur_byte & LOW7_MASK;
                    end
                end else if (is_lead && !unit_item.end_mark) begin
                    emit              = 1'b0;
                    lead_pending_next = 1'b1;
                    lead_byte_next    = cur_byte;
                end
            end
            default: begin
                high_val = 8'd0;
            end
        endcase
    end

    assign res_valid_next = (res_valid_reg & ~res_ready) | (unit_pop & emit);

    // Mode, lead state and result valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= MODE_SINGLE;
            lead_pending_reg <= 1'b0;
            lead_byte_reg    <= 8'd0;
            res_valid_reg    <= 1'b0;
        end else begin
            res_valid_reg <= res_valid_next;
            if (cfg_we) begin
                mode_reg         <= code_mode_t'(cfg_wdata);
                lead_pending_reg <= 1'b0;
                lead_byte_reg    <= 8'd0;
            end else if (unit_pop) begin
                lead_pending_reg <= lead_pending_next;
                lead_byte_reg    <= lead_byte_next;
            end
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (unit_pop && emit) begin
            high_reg <= high_val;
            low_reg  <= low_val;
            last_reg <= unit_item.end_mark;
        end
    end

    assign res_valid     = res_valid_reg;
    assign res_high_byte = high_reg;
    assign res_low_byte  = low_reg;
    assign res_last_char = last_reg;

endmodule

/* src/multibyte_to_twobyte_code_core.sv */
// ----------------------------------------------------------------------------
// multibyte_to_twobyte_code_core: code unit stream to two-byte font codes.
// Converts single-byte, sixteen-bit, Shift-JIS and EUC-KR code units into
// two-byte font codes, one result per completed character.
//
//   Channel | Direction | Payload
//   --------+-----------+-------------------------------------------------
//   s_      | in        | tdata: code_in[15:0]; tlast: end_mark
//   m_      | out       | tdata: high_byte[7:0], low_byte[15:8]; tlast: last_char
//   cfg_    | in        | cfg_wdata: code_mode[1:0], written when cfg_we is high
//
// One code unit is taken per cycle while the skid entry is free. The unit is
// loaded into the input register (or the skid entry) at its transfer edge and
// then converted into the result register, from which m_ takes the result.
// A lead byte that is held produces no transfer on the result side.
// Reset is synchronous and active low; it clears the mode to single byte.
// s_tready comes from a flop, so a stall on m_ is absorbed by a skid entry.
// ----------------------------------------------------------------------------
module multibyte_to_twobyte_code_core
    import mb2b_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write.
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,      // code_mode
    // Input code units.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,        // [15:0] code_in
    input  logic        s_tlast,
    // Output font codes.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,        // [7:0] high_byte, [15:8] low_byte
    output logic        m_tlast
);

    unit_item_t in_item;
    unit_item_t unit_item;
    logic       unit_valid;
    logic       unit_pop;
    logic [7:0] high_byte;
    logic [7:0] low_byte;

    assign in_item.code_in  = s_tdata;
    assign in_item.end_mark = s_tlast;

    // Input register with skid entry.
    mb2b_in_skid u_in_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .out_valid (unit_valid),
        .out_item  (unit_item),
        .out_pop   (unit_pop)
    );

    // Conversion and result register.
    mb2b_convert u_convert (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .unit_valid    (unit_valid),
        .unit_item     (unit_item),
        .unit_pop      (unit_pop),
        .res_valid     (m_tvalid),
        .res_ready     (m_tready),
        .res_high_byte (high_byte),
        .res_low_byte  (low_byte),
        .res_last_char (m_tlast)
    );

    assign m_tdata = {low_byte, high_byte};

endmodule

/* test/tb_multibyte_to_twobyte_code_core.sv */
// ----------------------------------------------------------------------------
// tb_multibyte_to_twobyte_code_core: self-checking bench for the code core.
// Code units are streamed into the core under all four conversion modes,
// first as a short directed set of lead/trail and boundary cases, then as
// random phases. A scoreboard predicts each font code from the accepted
// units and checks every result transfer in order. Both sides idle at
// random, and one long output stall backs the core up into its input.
// ----------------------------------------------------------------------------
module tb_multibyte_to_twobyte_code_core;
    import mb2b_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_UNITS  = 100;

    // One expected font code.
    typedef struct {
        logic [7:0] high_byte;
        logic [7:0] low_byte;
        logic       last_char;
    } font_code_t;

    // Predicts font codes from accepted units and checks result transfers.
    class font_code_board;
        font_code_t  codes_due[$];
        code_mode_t  mode;
        logic        lead_held;
        logic [7:0]  held_lead;
        int          errors;

        function new();
            mode      = MODE_SINGLE;
            lead_held = 1'b0;
            held_lead = 8'h00;
            errors    = 0;
        endfunction

        // A mode write drops any held lead byte.
        function void set_mode(code_mode_t m);
            mode      = m;
            lead_held = 1'b0;
            held_lead = 8'h00;
        endfunction

        function void note_unit(logic [15:0] unit, logic endm);
            font_code_t c;
            logic [7:0] b;
            logic [8:0] row;
            logic [7:0] cell_code;
            logic       is_lead;
            b           = unit[7:0];
            c.last_char = endm;
            c.high_byte = 8'h00;
            c.low_byte  = b;
            if (mode == MODE_SINGLE) begin
                codes_due.push_back(c);
                return;
            end
            if (mode == MODE_WIDE) begin
                c.high_byte = unit[15:8];
                codes_due.push_back(c);
                return;
            end
            // Any byte after a held lead is its trail.
            if (lead_held) begin
                if (mode == MODE_SJIS) begin
                    if (held_lead <= 8'h9f) begin
                        row = {held_lead, 1'b0} - 9'h0e0;
                    end else begin
                        row = {held_lead, 1'b0} - 9'h160;
                    end
                    if (b < 8'h9f) begin
                        row = row - 9'd1;
                        cell_code = (b < 8'h7f) ? b - 8'h1f : b - 8'h20;
                    end else begin
                        cell_code = b - 8'h7e;
                    end
                    c.high_byte = row[7:0];
                    c.low_byte  = cell_code;
                end else begin
                    c.high_byte = {1'b0, held_lead[6:0]};
                    c.low_byte  = {1'b0, b[6:0]};
                end
                lead_held = 1'b0;
                held_lead = 8'h00;
                codes_due.push_back(c);
                return;
            end
            if (mode == MODE_SJIS) begin
                is_lead = (b >= 8'h80 && b <= 8'h9f) || (b >= 8'he0 && b <= 8'hfc);
            end else begin
                is_lead = b[7];
            end
            // A lead at the end of a string is given as a single byte.
            if (is_lead && !endm) begin
                lead_held = 1'b1;
                held_lead = b;
                return;
            end
            codes_due.push_back(c);
        endfunction

        function void check_code(logic [15:0] tdata, logic tlast);
            font_code_t c;
            if (codes_due.size() == 0) begin
                $error("result transfer %h/%b with no code expected", tdata, tlast);
                errors++;
                return;
            end
            c = codes_due.pop_front();
            if (tdata[7:0] !== c.high_byte) begin
                $error("high_byte: expected %h, actual %h", c.high_byte, tdata[7:0]);
                errors++;
            end
            if (tdata[15:8] !== c.low_byte) begin
                $error("low_byte: expected %h, actual %h", c.low_byte, tdata[15:8]);
                errors++;
            end
            if (tlast !== c.last_char) begin
                $error("last_char: expected %b, actual %b", c.last_char, tlast);
                errors++;
            end
        endfunction

        function int pending();
            return codes_due.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;          // [15:0] code_in
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;          // [7:0] high_byte, [15:8] low_byte
    logic        m_tlast;

    font_code_board board;
    logic           reset_done;
    logic           no_gaps;
    logic           hold_request;
    logic           hold_done;
    int             cycle_count = 0;

    multibyte_to_twobyte_code_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Offers one unit after a random gap and waits for its transfer.
    task automatic send_unit(input logic [15:0] unit, input logic endm);
        int gap;
        gap = (no_gaps || (hold_request && !hold_done)) ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = unit;
        s_tlast  = endm;
        do @(posedge aclk); while (!s_tready);
        board.note_unit(unit, endm);
        @(negedge aclk);
    endtask

    // Lets every expected code arrive and the core settle.
    task automatic drain();
        s_tvalid = 1'b0;
        while (board.pending() > 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Writes the mode register while the core is idle.
    task automatic write_mode(input code_mode_t m);
        drain();
        cfg_we    = 1'b1;
        cfg_wdata = m;
        @(posedge aclk);
        board.set_mode(m);
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    // Random unit, biased toward lead and trail bytes in the paired modes.
    function automatic logic [15:0] random_unit(input code_mode_t m);
        logic [15:0] unit;
        int          pick;
        unit = 16'($urandom);
        pick = $urandom_range(0, 9);
        if (m == MODE_SJIS) begin
            case (pick)
                0, 1:    unit[7:0] = 8'($urandom_range(8'h80, 8'h9f));
                2, 3:    unit[7:0] = 8'($urandom_range(8'he0, 8'hfc));
                4, 5, 6: unit[7:0] = 8'($urandom_range(8'h40, 8'hfc));
                default: ;
            endcase
        end else if (m == MODE_EUC && pick < 7) begin
            unit[7] = 1'b1;
        end
        return unit;
    endfunction

    // Result side: random ready gaps, plus one long hold when asked.
    initial begin
        int idle_cycles;
        m_tready  = 1'b0;
        hold_done = 1'b0;
        wait (reset_done === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                m_tready  = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            idle_cycles = no_gaps ? 0 : $urandom_range(0, 6);
            if (idle_cycles > 0) begin
                m_tready = 1'b0;
                repeat (idle_cycles) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            board.check_code(m_tdata, m_tlast);
        end
    end

    // Main sequence: reset, directed cases, random phases, final check.
    initial begin
        code_mode_t phase_modes [8];
        board        = new();
        reset_done   = 1'b0;
        no_gaps      = 1'b0;
        hold_request = 1'b0;
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = MODE_SINGLE;
        s_tvalid     = 1'b0;
        s_tdata      = 16'h0000;
        s_tlast      = 1'b0;
        phase_modes  = '{MODE_SJIS, MODE_EUC, MODE_SJIS, MODE_SINGLE,
                         MODE_WIDE, MODE_EUC, MODE_SJIS, MODE_SJIS};

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn    = 1'b1;
        reset_done = 1'b1;

        // Single-byte mode straight out of reset.
        send_unit(16'h0000, 1'b0);
        send_unit(16'h80a5, 1'b0);
        send_unit(16'hffff, 1'b1);

        write_mode(MODE_WIDE);
        send_unit(16'h0000, 1'b0);
        send_unit(16'h1234, 1'b0);
        send_unit(16'hffff, 1'b1);

        // Shift-JIS: each trail band, both lead ranges, and non-leads.
        write_mode(MODE_SJIS);
        send_unit(16'h0081, 1'b0);
        send_unit(16'h0040, 1'b0);
        send_unit(16'h009f, 1'b0);
        send_unit(16'h0080, 1'b0);
        send_unit(16'h00e0, 1'b0);
        send_unit(16'h009f, 1'b0);
        send_unit(16'habfc, 1'b0);
        send_unit(16'hff00, 1'b1);
        send_unit(16'h0088, 1'b1);
        send_unit(16'h00a0, 1'b0);
        send_unit(16'h00fd, 1'b0);
        send_unit(16'h0081, 1'b0);

        // EUC-KR, entered with a Shift-JIS lead still held.
        write_mode(MODE_EUC);
        send_unit(16'h0080, 1'b0);
        send_unit(16'h00ff, 1'b1);
        send_unit(16'hff7f, 1'b0);
        send_unit(16'h00c1, 1'b1);
        send_unit(16'h00b0, 1'b0);

        // Random phases across all modes.
        foreach (phase_modes[p]) begin
            write_mode(phase_modes[p]);
            no_gaps = (p == 4);
            for (int i = 0; i < PHASE_UNITS; i++) begin
                if (p == 2 && i == 20) hold_request = 1'b1;
                send_unit(random_unit(phase_modes[p]), ($urandom_range(0, 7) == 0));
            end
            no_gaps = 1'b0;
        end

        drain();
        if (board.errors == 0 && board.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
